>>> rtl/sdfem_pkg.sv
// Shared constants, types and codes for the SPI duty frame error monitor.
package sdfem_pkg;

  // Log ring: index runs below LOG_DEPTH in steps of two.
  localparam int LOG_DEPTH = 256;
  localparam int LOG_IDX_W = $clog2(LOG_DEPTH);

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 10;
  localparam int BAND_W   = 10;
  localparam int DIFF_W   = 12;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_SMALL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LARGE  = 2'd2;

  localparam logic [BAND_W-1:0] BAND_SMALL_RST  = 10'd10;
  localparam logic [BAND_W-1:0] BAND_MEDIUM_RST = 10'd20;
  localparam logic [BAND_W-1:0] BAND_LARGE_RST  = 10'd50;

  // Frame slots
  localparam logic [1:0] SLOT_LOW   = 2'd0;
  localparam logic [1:0] SLOT_HIGH  = 2'd1;
  localparam logic [1:0] SLOT_SPARE = 2'd2;
  localparam logic [1:0] SLOT_LAST  = 2'd3;

  // Status bytes
  localparam logic [BYTE_W-1:0] ST_IDLE      = 8'hAA;
  localparam logic [BYTE_W-1:0] ST_FINE      = 8'hEA;
  localparam logic [BYTE_W-1:0] ST_POS_MINOR = 8'hBA;
  localparam logic [BYTE_W-1:0] ST_POS_MID   = 8'hCA;
  localparam logic [BYTE_W-1:0] ST_POS_SEV   = 8'hDA;
  localparam logic [BYTE_W-1:0] ST_NEG_MINOR = 8'hBB;
  localparam logic [BYTE_W-1:0] ST_NEG_MID   = 8'hCB;
  localparam logic [BYTE_W-1:0] ST_NEG_SEV   = 8'hDB;

  typedef struct packed {
    logic [BAND_W-1:0] small_lim;
    logic [BAND_W-1:0] medium_lim;
    logic [BAND_W-1:0] large_lim;
  } bands_t;

endpackage

>>> rtl/sdfem_if.sv
// Valid/ready channel interfaces for the SPI slot beats and the reply beats.
interface sdfem_req_if;
  logic                          valid;
  logic                          ready;
  logic [sdfem_pkg::BYTE_W-1:0]   rx_byte;
  logic [sdfem_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, rx_byte, adc_sample, input ready);
  modport sink   (input valid, rx_byte, adc_sample, output ready);
endinterface

interface sdfem_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sdfem_pkg::BYTE_W-1:0]   tx_byte;
  logic                          frame_done;
  logic [sdfem_pkg::SAMPLE_W-1:0] duty_value;
  logic [sdfem_pkg::BYTE_W-1:0]   log_address;
  logic [sdfem_pkg::BYTE_W-1:0]   log_low;
  logic [sdfem_pkg::BYTE_W-1:0]   log_high;

  modport source (output valid, tx_byte, frame_done, duty_value, log_address, log_low,
                  log_high, input ready);
  modport sink   (input valid, tx_byte, frame_done, duty_value, log_address, log_low,
                  log_high, output ready);
endinterface

>>> rtl/sdfem_status.sv
// Classifies the signed measured-minus-set difference into a status byte.
module sdfem_status (
  input  logic signed [sdfem_pkg::DIFF_W-1:0] diff,
  input  sdfem_pkg::bands_t                   bands,
  output logic        [sdfem_pkg::BYTE_W-1:0] status
);

  logic signed [sdfem_pkg::DIFF_W-1:0] s;
  logic signed [sdfem_pkg::DIFF_W-1:0] m;
  logic signed [sdfem_pkg::DIFF_W-1:0] l;

  assign s = $signed({2'b00, bands.small_lim});
  assign m = $signed({2'b00, bands.medium_lim});
  assign l = $signed({2'b00, bands.large_lim});

  // First matching rule wins; overlapping bands fall through in order.
  always_comb begin
    if ((diff > 0 && diff < s) || (diff < 0 && diff > -s)) begin
      status = sdfem_pkg::ST_FINE;
    end else if (diff >= s && diff < m) begin
      status = sdfem_pkg::ST_POS_MINOR;
    end else if (diff >= m && diff < l) begin
      status = sdfem_pkg::ST_POS_MID;
    end else if (diff >= l) begin
      status = sdfem_pkg::ST_POS_SEV;
    end else if (diff < 0 && diff >= -m) begin
      status = sdfem_pkg::ST_NEG_MINOR;
    end else if (diff < -m && diff > -l) begin
      status = sdfem_pkg::ST_NEG_MID;
    end else if (diff <= -l) begin
      status = sdfem_pkg::ST_NEG_SEV;
    end else begin
      status = sdfem_pkg::ST_IDLE;
    end
  end

endmodule

>>> rtl/spi_duty_frame_error_monitor.sv
// Top level: SPI frame handler with duty logging and ADC error monitor.
//
//   channel  dir  beat payload
//   req      in   rx_byte, adc_sample
//   rsp      out  tx_byte, frame_done, duty_value, log_address, log_low, log_high
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A request beat is processed in the cycle it is taken and its reply lands in the
// output register at that edge, from the status compare chain on the last slot.
// req.ready stays high while the output register is empty or being drained, so beats
// flow back to back. Synchronous reset returns to slot 0, log address 0, reply bytes
// 0xAA and default bands. A stalled reply holds its register and stalls req.
module spi_duty_frame_error_monitor (
  input  logic                               clk,
  input  logic                               rst,
  sdfem_req_if.sink                          req,
  sdfem_rsp_if.source                        rsp,
  input  logic                               cfg_we,
  input  logic [sdfem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdfem_pkg::BAND_W-1:0]       cfg_data
);

  localparam int IW = sdfem_pkg::LOG_IDX_W;
  localparam logic [IW:0] LOG_LIMIT = (IW+1)'(sdfem_pkg::LOG_DEPTH);
  localparam logic [IW:0] LOG_STEP  = (IW+1)'(2);

  sdfem_pkg::bands_t bands;

  logic [1:0]                        slot_count;
  logic [sdfem_pkg::BYTE_W-1:0]      held_low;
  logic [sdfem_pkg::BYTE_W-1:0]      held_high;
  logic [IW-1:0]                     log_index;
  logic [sdfem_pkg::BYTE_W-1:0]      reply_lo;
  logic [sdfem_pkg::BYTE_W-1:0]      reply_hi;
  logic [sdfem_pkg::BYTE_W-1:0]      reply_mag;

  logic                              take;
  logic [sdfem_pkg::SAMPLE_W-1:0]    duty;
  logic signed [sdfem_pkg::DIFF_W-1:0] diff;
  logic [sdfem_pkg::DIFF_W-1:0]      mag;
  logic [sdfem_pkg::BYTE_W-1:0]      status;
  logic [IW:0]                       idx_sum;
  logic [IW-1:0]                     log_index_next;
  logic [IW+7:0]                     idx_wide;
  logic [sdfem_pkg::BYTE_W-1:0]      tx_next;
  logic                              last_slot;

  assign take     = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign last_slot = (slot_count == sdfem_pkg::SLOT_LAST);

  // Only bits 5:4 of the low byte reach the duty.
  assign duty = {held_high, held_low[5:4]};
  assign diff = $signed({2'b00, req.adc_sample}) - $signed({2'b00, duty});
  assign mag  = (diff < 0) ? 12'(-diff) : 12'(diff);

  sdfem_status u_status (
    .diff   (diff),
    .bands  (bands),
    .status (status)
  );

  assign idx_sum        = {1'b0, log_index} + LOG_STEP;
  assign log_index_next = (idx_sum >= LOG_LIMIT) ? '0 : idx_sum[IW-1:0];
  assign idx_wide       = {8'b0, log_index};

  always_comb begin
    case (slot_count)
      sdfem_pkg::SLOT_LOW:   tx_next = reply_lo;
      sdfem_pkg::SLOT_HIGH:  tx_next = reply_hi;
      sdfem_pkg::SLOT_SPARE: tx_next = reply_mag;
      default:               tx_next = status;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bands.small_lim  <= sdfem_pkg::BAND_SMALL_RST;
      bands.medium_lim <= sdfem_pkg::BAND_MEDIUM_RST;
      bands.large_lim  <= sdfem_pkg::BAND_LARGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdfem_pkg::REG_BAND_SMALL:  bands.small_lim  <= cfg_data;
        sdfem_pkg::REG_BAND_MEDIUM: bands.medium_lim <= cfg_data;
        sdfem_pkg::REG_BAND_LARGE:  bands.large_lim  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= sdfem_pkg::SLOT_LOW;
      held_low   <= '0;
      held_high  <= '0;
      log_index  <= '0;
      reply_lo   <= sdfem_pkg::ST_IDLE;
      reply_hi   <= sdfem_pkg::ST_IDLE;
      reply_mag  <= sdfem_pkg::ST_IDLE;
    end else if (take) begin
      slot_count <= slot_count + 2'd1;
      if (slot_count == sdfem_pkg::SLOT_LOW) begin
        held_low <= req.rx_byte;
      end
      if (slot_count == sdfem_pkg::SLOT_HIGH) begin
        held_high <= req.rx_byte;
      end
      if (last_slot) begin
        log_index <= log_index_next;
        reply_lo  <= {req.adc_sample[1:0], 6'b0};
        reply_hi  <= req.adc_sample[9:2];
        reply_mag <= mag[7:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.tx_byte     <= tx_next;
      rsp.frame_done  <= last_slot;
      rsp.duty_value  <= last_slot ? duty : '0;
      rsp.log_address <= last_slot ? idx_wide[7:0] : '0;
      rsp.log_low     <= last_slot ? held_low : '0;
      rsp.log_high    <= last_slot ? held_high : '0;
    end
  end

endmodule

>>> rtl/sdfem_checker.sv
// Port-level checks for the SPI duty frame error monitor, bound to the top level.
module sdfem_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sdfem_pkg::BYTE_W-1:0]      tx_byte,
  input logic                              frame_done,
  input logic [sdfem_pkg::SAMPLE_W-1:0]    duty_value,
  input logic [sdfem_pkg::BYTE_W-1:0]      log_address,
  input logic [sdfem_pkg::BYTE_W-1:0]      log_low,
  input logic [sdfem_pkg::BYTE_W-1:0]      log_high
);

  // Counts delivered reply beats within a frame.
  logic [1:0] out_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_slot <= 2'd0;
    end else if (out_valid && out_ready) begin
      out_slot <= out_slot + 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(frame_done))
    else $error("reply changed while stalled");

  a_frame_every_fourth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_done == (out_slot == sdfem_pkg::SLOT_LAST)))
    else $error("frame_done out of step with the slot count");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> duty_value == '0 && log_address == '0 &&
                                 log_low == '0 && log_high == '0)
    else $error("log fields set outside a frame end");

  a_even_address: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !log_address[0])
    else $error("odd log address");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request stalled with empty output register");

endmodule

bind spi_duty_frame_error_monitor sdfem_checker u_sdfem_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .tx_byte     (rsp.tx_byte),
  .frame_done  (rsp.frame_done),
  .duty_value  (rsp.duty_value),
  .log_address (rsp.log_address),
  .log_low     (rsp.log_low),
  .log_high    (rsp.log_high)
);

>>> tb/sdfem_frame_checker.sv
// Checker for the frame handler: predicts each reply beat from the slot beats and compares.
module sdfem_frame_checker
  import sdfem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sdfem_req_if                 req,
  sdfem_rsp_if                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BAND_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0]   tx_byte;
    logic                frame_done;
    logic [SAMPLE_W-1:0] duty_value;
    logic [BYTE_W-1:0]   log_address;
    logic [BYTE_W-1:0]   log_low;
    logic [BYTE_W-1:0]   log_high;
  } reply_beat_t;

  reply_beat_t       replies_q[$];
  bands_t            bands;
  logic [1:0]        slot;
  logic [BYTE_W-1:0] duty_lo;
  logic [BYTE_W-1:0] duty_hi;
  int unsigned       log_ptr;
  logic [BYTE_W-1:0] reply_bytes [4];

  initial begin
    mismatches  = 0;
    replies_due = 0;
  end

  // First matching rule wins, so odd band orders fall through literally.
  function automatic logic [BYTE_W-1:0] band_status(int diff);
    int s;
    int m;
    int l;
    s = int'(bands.small_lim);
    m = int'(bands.medium_lim);
    l = int'(bands.large_lim);
    if ((diff > 0 && diff < s) || (diff < 0 && diff > -s)) return ST_FINE;
    if (diff >= s && diff < m) return ST_POS_MINOR;
    if (diff >= m && diff < l) return ST_POS_MID;
    if (diff >= l) return ST_POS_SEV;
    if (diff < 0 && diff >= -m) return ST_NEG_MINOR;
    if (diff < -m && diff > -l) return ST_NEG_MID;
    if (diff <= -l) return ST_NEG_SEV;
    return ST_IDLE;
  endfunction

  function automatic reply_beat_t predict_reply(logic [BYTE_W-1:0] rx,
                                                logic [SAMPLE_W-1:0] adc);
    reply_beat_t         r;
    logic [SAMPLE_W-1:0] duty;
    int                  diff;
    r = '0;
    case (slot)
      SLOT_LOW: begin
        duty_lo   = rx;
        r.tx_byte = reply_bytes[1];
      end
      SLOT_HIGH: begin
        duty_hi   = rx;
        r.tx_byte = reply_bytes[2];
      end
      SLOT_SPARE: begin
        r.tx_byte = reply_bytes[3];
      end
      default: begin
        // only bits 5:4 of the low byte reach the duty
        duty          = {duty_hi, duty_lo[5:4]};
        diff          = int'(adc) - int'(duty);
        r.frame_done  = 1'b1;
        r.duty_value  = duty;
        r.log_address = 8'(log_ptr);
        r.log_low     = duty_lo;
        r.log_high    = duty_hi;
        log_ptr       = (log_ptr + 2 >= LOG_DEPTH) ? 0 : log_ptr + 2;
        reply_bytes[1] = {adc[1:0], 6'b0};
        reply_bytes[2] = adc[SAMPLE_W-1:2];
        reply_bytes[0] = band_status(diff);
        reply_bytes[3] = 8'(diff < 0 ? -diff : diff);
        r.tx_byte     = reply_bytes[0];
      end
    endcase
    slot = slot + 2'd1;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: reply mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    if (rst) begin
      bands.small_lim  = BAND_SMALL_RST;
      bands.medium_lim = BAND_MEDIUM_RST;
      bands.large_lim  = BAND_LARGE_RST;
      slot    = SLOT_LOW;
      duty_lo = '0;
      duty_hi = '0;
      log_ptr = 0;
      for (int i = 0; i < 4; i++) reply_bytes[i] = ST_IDLE;
      replies_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BAND_SMALL:  bands.small_lim  = cfg_data;
          REG_BAND_MEDIUM: bands.medium_lim = cfg_data;
          REG_BAND_LARGE:  bands.large_lim  = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        replies_q.push_back(predict_reply(req.rx_byte, req.adc_sample));
      if (rsp.valid && rsp.ready) begin
        if (replies_q.size() == 0) begin
          report_mismatch($sformatf("beat with nothing pending, tx_byte 0x%0h", rsp.tx_byte));
        end else begin
          want = replies_q.pop_front();
          check_field("tx_byte", rsp.tx_byte, want.tx_byte);
          check_field("frame_done", rsp.frame_done, want.frame_done);
          check_field("duty_value", rsp.duty_value, want.duty_value);
          check_field("log_address", rsp.log_address, want.log_address);
          check_field("log_low", rsp.log_low, want.log_low);
          check_field("log_high", rsp.log_high, want.log_high);
        end
      end
    end
    replies_due = replies_q.size();
  end

endmodule

>>> tb/testbench.sv
// Top: clock, reset, SPI slot stimulus, reply back-pressure and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdfem_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int LONG_HOLD   = 64;
  localparam int PHASES      = 8;
  localparam int FRAMES      = 14;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BAND_W-1:0]    cfg_data;
  int                   mismatches;
  int                   replies_due;
  int                   cycles;
  bit                   tx_gaps;
  bit                   rx_gaps;
  bit                   long_hold_req;
  bands_t               cur;

  sdfem_req_if req_ch ();
  sdfem_rsp_if rsp_ch ();

  spi_duty_frame_error_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sdfem_frame_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Reply side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (long_hold_req) begin
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_beat(logic [BYTE_W-1:0] rx, logic [SAMPLE_W-1:0] adc);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.rx_byte    = rx;
    req_ch.adc_sample = adc;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Spare slots and the unused samples carry noise.
  task automatic send_frame(logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi,
                            logic [SAMPLE_W-1:0] adc);
    send_beat(lo, SAMPLE_W'($urandom));
    send_beat(hi, SAMPLE_W'($urandom));
    send_beat(BYTE_W'($urandom), SAMPLE_W'($urandom));
    send_beat(BYTE_W'($urandom), adc);
  endtask

  task automatic write_band(logic [CFG_IDX_W-1:0] idx, logic [BAND_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_BAND_SMALL:  cur.small_lim  = val;
      REG_BAND_MEDIUM: cur.medium_lim = val;
      REG_BAND_LARGE:  cur.large_lim  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_bands(int s, int m, int l);
    write_band(REG_BAND_SMALL, BAND_W'(s));
    write_band(REG_BAND_MEDIUM, BAND_W'(m));
    write_band(REG_BAND_LARGE, BAND_W'(l));
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (replies_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sample aimed at a band edge (one below, on, one above) or anywhere.
  function automatic logic [SAMPLE_W-1:0] aim_sample(logic [SAMPLE_W-1:0] duty);
    int lim;
    int delta;
    int v;
    case ($urandom_range(0, 4))
      0: return SAMPLE_W'($urandom);
      1: lim = int'(cur.small_lim);
      2: lim = int'(cur.medium_lim);
      3: lim = int'(cur.large_lim);
      default: lim = 0;
    endcase
    delta = lim + int'($urandom_range(0, 2)) - 1;
    if ($urandom_range(0, 1) == 1) delta = -delta;
    v = int'(duty) + delta;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    int                s;
    int                m;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.rx_byte    = '0;
    req_ch.adc_sample = '0;
    tx_gaps           = 1'b1;
    rx_gaps           = 1'b1;
    long_hold_req     = 1'b0;
    cur.small_lim     = BAND_SMALL_RST;
    cur.medium_lim    = BAND_MEDIUM_RST;
    cur.large_lim     = BAND_LARGE_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed frames on the reset bands
    send_frame(8'h00, 8'h00, 10'd0);     // zero difference
    send_frame(8'h30, 8'h40, 10'd264);   // duty 259, fine
    send_frame(8'h10, 8'h40, 10'd272);   // duty 257, small band
    send_frame(8'hCF, 8'h40, 10'd286);   // high low-byte bits dropped, medium band
    send_frame(8'h00, 8'h00, 10'd1023);  // severe, magnitude truncated
    send_frame(8'hFF, 8'hFF, 10'd0);     // full duty, severe negative

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: ;
        1: set_bands(1, 1, 1);
        2: set_bands(1023, 1023, 1023);
        3: set_bands(50, 20, 10);        // inverted bands
        4: set_bands(0, 0, 0);
        6: set_bands($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
        default: begin
          s = $urandom_range(1, 300);
          m = s + $urandom_range(0, 300);
          set_bands(s, m, m + $urandom_range(0, 400));
        end
      endcase
      tx_gaps = (ph < PHASES - 1) && (ph != 3) && ($urandom_range(0, 3) != 0);
      rx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int f = 0; f < FRAMES; f++) begin
        if (ph == 3 && f == 4) long_hold_req = 1'b1;
        lo = BYTE_W'($urandom);
        hi = BYTE_W'($urandom);
        send_frame(lo, hi, aim_sample({hi, lo[5:4]}));
      end
    end

    req_ch.valid = 1'b0;
    while (replies_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
